@@ rtl/ekc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ekc_pkg;

    // payload widths
    localparam int COUNT_W = 16;
    localparam int LEVEL_W = 5;
    localparam int EVT_W   = 12;
    localparam int TIMER_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // encoder window and timer cap
    localparam logic [COUNT_W-1:0] TRACK_CENTER = 16'h8000;
    localparam logic [COUNT_W-1:0] TRACK_HIGH   = 16'hfff0;
    localparam logic [COUNT_W-1:0] TRACK_LOW    = 16'h000f;
    localparam logic [TIMER_W-1:0] TIMER_CAP    = 16'd65530;

    // register reset values
    localparam logic [TIMER_W-1:0] SHORT_TICKS_RST = 16'd5;
    localparam logic [TIMER_W-1:0] LONG_TICKS_RST  = 16'd100;

    // key slots that have bits in the event word
    localparam int KEY_SLOTS = (EVT_W - 2) / 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = 2'd1;

    // event bit positions of the encoder
    localparam int EV_UP   = 0;
    localparam int EV_DOWN = 1;

    typedef struct packed {
        logic up;
        logic down;
        logic reload;
    } t_enc_evt;

    typedef struct packed {
        logic short_ev;
        logic long_ev;
    } t_key_evt;

endpackage

`default_nettype wire

@@ rtl/ekc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// input tick channel
interface ekc_in_if;
    import ekc_pkg::*;
    logic                valid;
    logic                ready;
    logic [COUNT_W-1:0]  encoder_count;
    logic [LEVEL_W-1:0]  key_levels;
    logic                clear_events;
    modport source (output valid, encoder_count, key_levels, clear_events, input ready);
    modport sink   (input valid, encoder_count, key_levels, clear_events, output ready);
endinterface

// result channel
interface ekc_out_if;
    import ekc_pkg::*;
    logic              valid;
    logic              ready;
    logic [EVT_W-1:0]  new_events;
    logic [EVT_W-1:0]  held_events;
    logic              counter_reload;
    modport source (output valid, new_events, held_events, counter_reload, input ready);
    modport sink   (input valid, new_events, held_events, counter_reload, output ready);
endinterface

// register write channel
interface ekc_cfg_if;
    import ekc_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/encoder_and_key_press_classifier_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// a tick accepted into the input register moves to the result register once that is free
// throughput: one tick per cycle; input register feeds the result register directly
// ready drops only while both the input and result registers hold unread beats
// reset (synchronous, active low): tracked count 32768, key timers and sticky flags zero,
// short threshold 5, long threshold 100, both channels empty
module encoder_and_key_press_classifier_core #(
    parameter int NUM_KEYS = 5
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ekc_in_if.sink    i_in,
    ekc_out_if.source o_out,
    ekc_cfg_if.sink   i_cfg
);
    import ekc_pkg::*;

    // input register
    logic               r_in_valid;
    logic [COUNT_W-1:0] r_in_count;
    logic [LEVEL_W-1:0] r_in_levels;
    logic               r_in_clear;

    // result register and sticky flags
    logic               r_out_valid;
    logic [EVT_W-1:0]   r_out_new;
    logic               r_out_reload;
    logic [EVT_W-1:0]   r_held;
    logic [EVT_W-1:0]   n_held;
    logic [EVT_W-1:0]   n_ev;

    // thresholds
    logic [TIMER_W-1:0] r_short_ticks;
    logic [TIMER_W-1:0] r_long_ticks;

    logic               w_out_free;
    logic               w_adv;
    logic               w_in_take;
    t_enc_evt           w_enc_evt;
    logic [COUNT_W-1:0] w_track;
    t_key_evt           w_key_evt [NUM_KEYS];
    logic [KEY_SLOTS-1:0] w_short;
    logic [KEY_SLOTS-1:0] w_long;

    // handshake
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_adv       = r_in_valid && w_out_free;
    assign i_in.ready  = !r_in_valid || w_out_free;
    assign w_in_take   = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_count  <= i_in.encoder_count;
            r_in_levels <= i_in.key_levels;
            r_in_clear  <= i_in.clear_events;
        end
    end

    // register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_ticks <= SHORT_TICKS_RST;
            r_long_ticks  <= LONG_TICKS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_SHORT_PRESS: r_short_ticks <= i_cfg.data;
                CFG_LONG_PRESS:  r_long_ticks  <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // encoder tracker
    ekc_encoder u_enc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_count (r_in_count),
        .o_evt   (w_enc_evt),
        .o_track (w_track)
    );

    // per-key press timers, keys past the level field read released
    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
        logic w_pressed;
        if (k < LEVEL_W) begin : g_pin
            assign w_pressed = !r_in_levels[k];
        end else begin : g_nopin
            assign w_pressed = 1'b0;
        end
        ekc_key u_key (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_en          (w_adv),
            .i_pressed     (w_pressed),
            .i_short_ticks (r_short_ticks),
            .i_long_ticks  (r_long_ticks),
            .o_evt         (w_key_evt[k])
        );
    end

    // keys whose bits fall past the event word are dropped
    for (genvar s = 0; s < KEY_SLOTS; s++) begin : g_slot
        if (s < NUM_KEYS) begin : g_used
            assign w_short[s] = w_key_evt[s].short_ev;
            assign w_long[s]  = w_key_evt[s].long_ev;
        end else begin : g_empty
            assign w_short[s] = 1'b0;
            assign w_long[s]  = 1'b0;
        end
    end

    // event word and sticky flags
    always_comb begin
        n_ev          = '0;
        n_ev[EV_UP]   = w_enc_evt.up;
        n_ev[EV_DOWN] = w_enc_evt.down;
        for (int s = 0; s < KEY_SLOTS; s++) begin
            n_ev[2*s+2] = w_short[s];
            n_ev[2*s+3] = w_long[s];
        end
        n_held = (r_in_clear ? '0 : r_held) | n_ev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_held      <= '0;
        end else begin
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (w_adv) begin
                r_held <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_new    <= n_ev;
            r_out_reload <= w_enc_evt.reload;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.new_events     = r_out_new;
    assign o_out.held_events    = r_held;
    assign o_out.counter_reload = r_out_reload;

    // up and down never come in the same beat
    a_up_down_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_new[EV_UP] && r_out_new[EV_DOWN]))
        else $error("up and down events in one beat");

    // every new event is also in the sticky flags
    a_held_covers_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_held & r_out_new) == r_out_new))
        else $error("sticky flags miss a new event");

    // a reload leaves the tracked count centered
    a_reload_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_enc_evt.reload) |=> (w_track == TRACK_CENTER))
        else $error("tracked count not centered after reload");

    // sticky flags only move when a tick is processed
    a_held_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_held))
        else $error("sticky flags changed without a tick");

endmodule

`default_nettype wire

@@ rtl/ekc_encoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ekc_encoder (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic [ekc_pkg::COUNT_W-1:0] i_count,
    output ekc_pkg::t_enc_evt           o_evt,
    output logic [ekc_pkg::COUNT_W-1:0] o_track
);
    import ekc_pkg::*;

    logic [COUNT_W-1:0] r_track;
    logic [COUNT_W-1:0] n_track;
    logic [COUNT_W:0]   w_up_diff;
    logic [COUNT_W:0]   w_dn_diff;
    logic [COUNT_W-1:0] w_stepped;
    logic               w_up;
    logic               w_down;
    logic               w_reload;

    // distance to the counter in both directions, msb is the borrow
    assign w_up_diff = {1'b0, i_count} - {1'b0, r_track};
    assign w_dn_diff = {1'b0, r_track} - {1'b0, i_count};
    assign w_up   = !w_up_diff[COUNT_W] && (w_up_diff[COUNT_W-1:1] != '0);
    assign w_down = !w_dn_diff[COUNT_W] && (w_dn_diff[COUNT_W-1:1] != '0);

    // step by two, then recenter outside the safe window
    always_comb begin
        priority if (w_up) begin
            w_stepped = r_track + COUNT_W'(2);
        end else if (w_down) begin
            w_stepped = r_track - COUNT_W'(2);
        end else begin
            w_stepped = r_track;
        end
        w_reload = (w_stepped > TRACK_HIGH) || (w_stepped < TRACK_LOW);
        n_track  = w_reload ? TRACK_CENTER : w_stepped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track <= TRACK_CENTER;
        end else if (i_en) begin
            r_track <= n_track;
        end
    end

    assign o_evt.up     = w_up;
    assign o_evt.down   = w_down;
    assign o_evt.reload = w_reload;
    assign o_track      = r_track;

endmodule

`default_nettype wire

@@ rtl/ekc_key.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ekc_key (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_pressed,
    input  wire logic [ekc_pkg::TIMER_W-1:0] i_short_ticks,
    input  wire logic [ekc_pkg::TIMER_W-1:0] i_long_ticks,
    output ekc_pkg::t_key_evt                o_evt
);
    import ekc_pkg::*;

    logic [TIMER_W-1:0] r_timer;
    logic [TIMER_W-1:0] n_timer;
    logic [TIMER_W-1:0] w_inc;

    assign w_inc = r_timer + TIMER_W'(1);

    // long fires on reaching the threshold, short on release inside the window
    assign o_evt.long_ev  = i_pressed && (w_inc == i_long_ticks);
    assign o_evt.short_ev = !i_pressed && (r_timer > i_short_ticks)
                            && (r_timer < i_long_ticks);

    // held timer wraps back just past the long threshold near the top
    always_comb begin
        if (i_pressed) begin
            n_timer = (w_inc > TIMER_CAP) ? (i_long_ticks + TIMER_W'(1)) : w_inc;
        end else begin
            n_timer = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer <= '0;
        end else if (i_en) begin
            r_timer <= n_timer;
        end
    end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import ekc_pkg::*;

    localparam int NUM_KEYS        = 5;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SWEEP_TICKS     = 40;
    localparam int PHASE_TICKS     = 60;

    // register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

    typedef struct packed {
        logic [EVT_W-1:0] new_ev;
        logic [EVT_W-1:0] held;
        logic             reload;
    } tick_result_t;

    logic i_clk;
    logic i_rst_n;

    ekc_in_if  in_bus ();
    ekc_out_if out_bus ();
    ekc_cfg_if cfg_bus ();

    encoder_and_key_press_classifier_core #(
        .NUM_KEYS(NUM_KEYS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus),
        .i_cfg  (cfg_bus)
    );

    // predictor state
    logic [COUNT_W-1:0] trk_model;
    logic [TIMER_W-1:0] key_timer [NUM_KEYS];
    logic [EVT_W-1:0]   sticky_model;
    logic [TIMER_W-1:0] short_ticks;
    logic [TIMER_W-1:0] long_ticks;

    tick_result_t predicted_q [$];
    int err_count;
    int cycle_count;

    // stimulus state
    int  tx_burst_left;
    bit  tx_full_speed;
    bit  rx_full_speed;
    bit  rx_hold_req;
    int  hold_left [LEVEL_W];
    int  gap_left  [LEVEL_W];
    logic [COUNT_W-1:0] knob_pos;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic reset_model();
        trk_model    = TRACK_CENTER;
        sticky_model = '0;
        short_ticks  = SHORT_TICKS_RST;
        long_ticks   = LONG_TICKS_RST;
        for (int k = 0; k < NUM_KEYS; k++) key_timer[k] = '0;
    endtask

    // one tick: encoder tracking, key timers, sticky flags
    function automatic tick_result_t classify_tick(input logic [COUNT_W-1:0] cnt,
                                                   input logic [LEVEL_W-1:0] lv,
                                                   input logic clr);
        tick_result_t r;
        logic [EVT_W-1:0]   ev;
        logic [TIMER_W-1:0] t;
        logic               pressed;
        ev = '0;
        r.reload = 1'b0;
        if (cnt > trk_model) begin
            if (cnt - trk_model > 16'd1) begin
                trk_model = trk_model + 16'd2;
                ev[EV_UP] = 1'b1;
            end
        end else if (cnt < trk_model) begin
            if (trk_model - cnt > 16'd1) begin
                trk_model = trk_model - 16'd2;
                ev[EV_DOWN] = 1'b1;
            end
        end
        if (trk_model > TRACK_HIGH || trk_model < TRACK_LOW) begin
            trk_model = TRACK_CENTER;
            r.reload = 1'b1;
        end
        for (int k = 0; k < NUM_KEYS; k++) begin
            t = key_timer[k];
            pressed = (k < LEVEL_W) ? ~lv[k] : 1'b0;
            if (pressed) begin
                t = t + 16'd1;
                if (t == long_ticks && 2 * k + 3 < EVT_W) ev[2 * k + 3] = 1'b1;
                if (t > TIMER_CAP) t = long_ticks + 16'd1;
            end else begin
                if (t > short_ticks && t < long_ticks && 2 * k + 2 < EVT_W)
                    ev[2 * k + 2] = 1'b1;
                t = '0;
            end
            key_timer[k] = t;
        end
        if (clr) sticky_model = '0;
        sticky_model = sticky_model | ev;
        r.new_ev = ev;
        r.held   = sticky_model;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < 40) $display("mismatch: %s got %0h want %0h", what, got, want);
        err_count++;
    endtask

    // accepted register writes and ticks feed the predictor
    always @(posedge i_clk) begin : track_beats
        if (i_rst_n) begin
            if (cfg_bus.valid && cfg_bus.ready) begin
                case (cfg_bus.index)
                    CFG_SHORT_PRESS: short_ticks = cfg_bus.data;
                    CFG_LONG_PRESS:  long_ticks  = cfg_bus.data;
                    default: ;
                endcase
            end
            if (in_bus.valid && in_bus.ready)
                predicted_q.push_back(classify_tick(in_bus.encoder_count,
                                                    in_bus.key_levels,
                                                    in_bus.clear_events));
        end
    end

    // each result beat against the oldest prediction
    always @(posedge i_clk) begin : check_results
        tick_result_t want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (predicted_q.size() == 0) begin
                report_mismatch("result with no tick pending", out_bus.new_events, 0);
            end else begin
                want = predicted_q.pop_front();
                if (out_bus.new_events !== want.new_ev)
                    report_mismatch("new_events", out_bus.new_events, want.new_ev);
                if (out_bus.held_events !== want.held)
                    report_mismatch("held_events", out_bus.held_events, want.held);
                if (out_bus.counter_reload !== want.reload)
                    report_mismatch("counter_reload", out_bus.counter_reload, want.reload);
            end
        end
    end

    // receiver: run/stall pattern, full speed, or a long hold-off on request
    initial begin : rx_pattern
        int   left;
        logic level;
        out_bus.ready = 1'b0;
        left  = 0;
        level = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                out_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end else if (rx_full_speed) begin
                out_bus.ready <= 1'b1;
            end else begin
                if (left == 0) begin
                    level = ~level;
                    left  = level ? $urandom_range(1, 10) : $urandom_range(1, 5);
                end
                out_bus.ready <= level;
                left--;
            end
        end
    end

    // offer one tick, with a random gap when a burst runs out; valid stays high after
    task automatic send_tick(input logic [COUNT_W-1:0] cnt, input logic [LEVEL_W-1:0] lv,
                             input logic clr);
        int gap;
        if (!tx_full_speed && tx_burst_left == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            in_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            tx_burst_left = $urandom_range(1, 12);
        end
        @(negedge i_clk);
        in_bus.valid         <= 1'b1;
        in_bus.encoder_count <= cnt;
        in_bus.key_levels    <= lv;
        in_bus.clear_events  <= clr;
        do @(posedge i_clk); while (!in_bus.ready);
        if (tx_burst_left > 0) tx_burst_left--;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge i_clk); while (!cfg_bus.ready);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // stop offering and wait until every predicted result has arrived
    task automatic wait_results_drained();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (predicted_q.size() != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_thresholds(input logic [TIMER_W-1:0] s, input logic [TIMER_W-1:0] l);
        wait_results_drained();
        write_reg(CFG_SHORT_PRESS, s);
        write_reg(CFG_LONG_PRESS, l);
    endtask

    // press length aimed at the thresholds
    function automatic int pick_hold();
        int d;
        case ($urandom_range(0, 6))
            0:       d = short_ticks;
            1:       d = short_ticks + 1;
            2:       d = long_ticks - 1;
            3:       d = long_ticks;
            4:       d = long_ticks + 1;
            default: d = $urandom_range(1, 16);
        endcase
        if (d < 1 || d > 200) d = $urandom_range(1, 16);
        return d;
    endfunction

    // press/release scripts per key, a wandering knob, some noise
    task automatic make_random_tick(output logic [COUNT_W-1:0] cnt,
                                    output logic [LEVEL_W-1:0] lv, output logic clr);
        for (int k = 0; k < LEVEL_W; k++) begin
            if (hold_left[k] > 0) begin
                lv[k] = 1'b0;
                hold_left[k]--;
                if (hold_left[k] == 0) gap_left[k] = $urandom_range(1, 3);
            end else begin
                lv[k] = 1'b1;
                if (gap_left[k] > 0) gap_left[k]--;
                if (gap_left[k] == 0) hold_left[k] = pick_hold();
            end
        end
        if ($urandom_range(0, 99) < 12) lv = LEVEL_W'($urandom_range(0, 31));
        if ($urandom_range(0, 99) < 6) begin
            cnt = COUNT_W'($urandom_range(0, 65535));
        end else begin
            knob_pos = knob_pos + 16'($urandom_range(0, 6)) - 16'd3;
            cnt = knob_pos + 16'($urandom_range(0, 2)) - 16'd1;
        end
        clr = ($urandom_range(0, 99) < 8);
    endtask

    // encoder steps of size 0/1/2, window of the tracker, short press edges, clear
    task automatic test_directed_edges();
        send_tick(16'h8000, 5'h1f, 1'b0);
        send_tick(16'h8001, 5'h1f, 1'b0);
        send_tick(16'h8002, 5'h1f, 1'b0);
        send_tick(16'h8001, 5'h1f, 1'b0);
        send_tick(16'h0000, 5'h1f, 1'b0);
        send_tick(16'hffff, 5'h1f, 1'b0);
        send_tick(16'h7fff, 5'h00, 1'b0);
        repeat (6) send_tick(16'h8000, 5'h00, 1'b0);
        // release of all keys above the short threshold
        send_tick(16'h8000, 5'h1f, 1'b0);
        send_tick(16'h8000, 5'h1f, 1'b1);
        // key 0 released exactly at the short threshold, key 1 one tick later
        repeat (5) send_tick(16'h8000, 5'b11100, 1'b0);
        send_tick(16'h8000, 5'b11101, 1'b0);
        send_tick(16'h8000, 5'h1f, 1'b1);
    endtask

    // receiver holds off while the sender keeps offering at full rate
    task automatic test_backpressure();
        logic [COUNT_W-1:0] cnt;
        logic [LEVEL_W-1:0] lv;
        logic               clr;
        wait_results_drained();
        tx_full_speed = 1'b1;
        rx_hold_req   = 1'b1;
        repeat (24) begin
            make_random_tick(cnt, lv, clr);
            send_tick(cnt, lv, clr);
        end
        tx_full_speed = 1'b0;
    endtask

    // random press sequences under several threshold settings
    task automatic test_random_ticks();
        logic [TIMER_W-1:0] s_tab [7];
        logic [TIMER_W-1:0] l_tab [7];
        logic [COUNT_W-1:0] cnt;
        logic [LEVEL_W-1:0] lv;
        logic               clr;
        s_tab = '{16'd0, 16'd3, 16'd12, 16'd2, 16'd0, 16'd7, 16'd5};
        l_tab = '{16'd1, 16'd12, 16'd3, 16'd3, 16'd1, 16'd65535, 16'd100};
        s_tab[4] = TIMER_W'($urandom_range(0, 40));
        l_tab[4] = TIMER_W'($urandom_range(1, 60));
        for (int p = 0; p < 7; p++) begin
            set_thresholds(s_tab[p], l_tab[p]);
            if (p == 3) begin
                // writes to undecoded indexes must change nothing
                write_reg(CFG_UNUSED_A, CFG_DATA_W'($urandom_range(0, 65535)));
                write_reg(CFG_UNUSED_B, CFG_DATA_W'($urandom_range(0, 65535)));
            end
            repeat (PHASE_TICKS) begin
                make_random_tick(cnt, lv, clr);
                send_tick(cnt, lv, clr);
            end
        end
    endtask

    // tracker driven hard toward both ends of its range; two keys held under top thresholds
    task automatic test_long_runs();
        logic [LEVEL_W-1:0] lv;
        set_thresholds(16'd65529, 16'd65530);
        tx_full_speed = 1'b1;
        rx_full_speed = 1'b1;
        repeat (SWEEP_TICKS) begin
            lv = {3'($urandom_range(0, 7)), 2'b00};
            send_tick(16'($urandom_range(16'hfff2, 16'hffff)), lv, 1'($urandom_range(0, 1)));
        end
        repeat (SWEEP_TICKS) begin
            lv = {3'($urandom_range(0, 7)), 2'b00};
            send_tick(16'($urandom_range(0, 14)), lv, 1'($urandom_range(0, 1)));
        end
        send_tick(16'h8000, 5'h1f, 1'b0);
        wait_results_drained();
        tx_full_speed = 1'b0;
        rx_full_speed = 1'b0;
    endtask

    initial begin
        i_rst_n              = 1'b0;
        in_bus.valid         = 1'b0;
        in_bus.encoder_count = '0;
        in_bus.key_levels    = '1;
        in_bus.clear_events  = 1'b0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = CFG_SHORT_PRESS;
        cfg_bus.data         = '0;
        err_count            = 0;
        tx_burst_left        = 0;
        tx_full_speed        = 1'b0;
        rx_full_speed        = 1'b0;
        rx_hold_req          = 1'b0;
        knob_pos             = TRACK_CENTER;
        for (int k = 0; k < LEVEL_W; k++) begin
            hold_left[k] = 0;
            gap_left[k]  = 0;
        end
        reset_model();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_backpressure();
        test_random_ticks();
        test_long_runs();

        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (predicted_q.size() != 0)
            report_mismatch("results never delivered", predicted_q.size(), 0);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
